>>> design/rttf_pkg.sv
// ----------------------------------------------------------------------------
// rttf_pkg: shared types and constants for the timeslot table finder
// Table entry layout, action codes, sequencer states and the time constants.
// ----------------------------------------------------------------------------
package rttf_pkg;

	// table geometry
	localparam int SLOTS = 32;
	localparam int IDX_W = $clog2(SLOTS);

	// time fields
	localparam int QMS_W = 16;
	localparam int MS_W  = 10;
	localparam int MS_PER_S = 1000;

	// reciprocal of 1000 for the time reduction, kept just below 2^22 / 1000
	// so that the quotient is never too large and is at most one too small
	localparam int RECIP       = 4194;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 22;
	localparam int PROD_W      = QMS_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	// action codes
	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_FIRST = 3'd1,
		ACT_NEXT  = 3'd2,
		ACT_START = 3'd3,
		ACT_FIT   = 3'd4
	} action_t;

	// one table entry, zone in the lowest bits
	typedef struct packed {
		logic [IDX_W-1:0] next;
		logic [MS_W-1:0]  duration;
		logic [MS_W-1:0]  start;
		logic [3:0]       source;
		logic [2:0]       zone;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD_WAIT,
		ST_SCAN,
		ST_NX_CHECK,
		ST_NX_FINAL,
		ST_WALK,
		ST_RESP
	} state_t;

endpackage

>>> design/rttf_ms_mod.sv
// ----------------------------------------------------------------------------
// rttf_ms_mod: millisecond count reduced modulo one second
// Two stages: reciprocal multiply for the quotient, then remainder with a
// single correcting subtract. The result holds until the next load.
// ----------------------------------------------------------------------------
module rttf_ms_mod
	import rttf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [QMS_W-1:0] ms_in,
	output logic [MS_W-1:0]  t_ms
);

	logic               vld_s1;
	logic [QMS_W-1:0]   x_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [QUOT_W-1:0]  quot;
	logic [QMS_W:0]     rem_wide;
	logic [MS_W:0]      rem;
	logic [MS_W-1:0]    t_s2;

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= load;
		end
	end

	// quotient estimate by reciprocal multiply
	always_ff @(posedge clk) begin
		if (load) begin
			x_s1    <= ms_in;
			prod_s1 <= PROD_W'(ms_in) * PROD_W'(RECIP);
		end
	end

	// remainder lies in 0 .. 1999, one subtract brings it into range
	assign quot     = prod_s1[PROD_W-1:RECIP_SHIFT];
	assign rem_wide = {1'b0, x_s1} - ((QMS_W+1)'(quot) * (QMS_W+1)'(MS_PER_S));
	assign rem      = rem_wide[MS_W:0];

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (rem >= (MS_W+1)'(MS_PER_S)) begin
				t_s2 <= MS_W'(rem - (MS_W+1)'(MS_PER_S));
			end else begin
				t_s2 <= rem[MS_W-1:0];
			end
		end
	end

	assign t_ms = t_s2;

endmodule

>>> design/radio_timeslot_table_finder.sv
// ----------------------------------------------------------------------------
// radio_timeslot_table_finder: transmit timeslot table with ring lookups
// Single-port-read table memory driven by a sequencer for entry writes,
// zone/source scans and bounded two-pass ring walks.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// s_axis    in         s_axis_tvalid/tready       request, 72-bit tdata
// m_axis    out        m_axis_tvalid/tready       answer, 8-bit tdata
// cfg       in         cfg_we                     none_index in cfg_wdata
//
// One request is in work at a time; a ring walk cannot issue its next read
// before the previous entry is back. Write or unused action: no lookup.
// First slot: a 32-entry scan. Next slot: an entry check, then a scan if
// the zone differs. Fitting slot: two passes of 32 reads. Next starting
// slot: a scan, then both passes. Reset clears the sequencer, the answer
// valid flag and none_index; the table holds no reset value. A stalled
// answer does not block the next request; that request then waits in ST_RESP.
//
module radio_timeslot_table_finder
	import rttf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request: action, entry_index, entry_zone, entry_source, entry_start_ms,
	// entry_duration_ms, entry_next, query_ms, query_zone, query_source,
	// query_index
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	// answer: slot_index, found
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	// none_index register
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	// request fields
	action_t          in_action;
	logic [IDX_W-1:0] in_entry_index;
	entry_t           in_entry;
	logic [QMS_W-1:0] in_query_ms;
	logic [2:0]       in_query_zone;
	logic [3:0]       in_query_source;
	logic [IDX_W-1:0] in_query_index;
	logic             in_acc;

	assign in_action              = action_t'(s_axis_tdata[2:0]);
	assign in_entry_index         = s_axis_tdata[7:3];
	assign in_entry.zone          = s_axis_tdata[10:8];
	assign in_entry.source        = s_axis_tdata[14:11];
	assign in_entry.start         = s_axis_tdata[24:15];
	assign in_entry.duration      = s_axis_tdata[34:25];
	assign in_entry.next          = s_axis_tdata[39:35];
	assign in_query_ms            = s_axis_tdata[55:40];
	assign in_query_zone          = s_axis_tdata[58:56];
	assign in_query_source        = s_axis_tdata[62:59];
	assign in_query_index         = s_axis_tdata[67:63];

	state_t           state_q, state_d;
	logic [IDX_W-1:0] none_q;
	action_t          op_q;
	logic [2:0]       qzone_q;
	logic [IDX_W-1:0] qidx_q;
	logic [2:0]       tz_q;
	logic [3:0]       ts_q;
	logic [IDX_W:0]   cnt_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] steps_q;
	logic             pass_q;
	logic [IDX_W-1:0] res_q;
	logic             found_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_slot_q;
	logic             out_found_q;

	entry_t           mem [SLOTS];
	entry_t           rd_entry;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [MS_W-1:0]  t_ms;

	logic             scan_hit, scan_miss;
	logic [IDX_W-1:0] scan_pos;
	logic [MS_W:0]    off;
	logic [MS_W:0]    tt;
	logic [MS_W:0]    win_end;
	logic             walk_hit;
	logic             pass_end;
	logic             out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign mem_we        = in_acc && (in_action == ACT_WRITE);

	// time of day within the second
	rttf_ms_mod u_ms_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_acc),
		.ms_in  (in_query_ms),
		.t_ms   (t_ms)
	);

	// timeslot table, writes only from idle so no lookup read overlaps a write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[in_entry_index] <= in_entry;
		end
		rd_entry <= mem[rd_addr];
	end

	// scan compare on the entry read last cycle
	assign scan_hit  = pend_s1 && (rd_entry.zone == tz_q) && (rd_entry.source == ts_q);
	assign scan_miss = pend_s1 && !scan_hit && (pidx_s1 == IDX_W'(SLOTS-1));
	assign scan_pos  = scan_hit ? pidx_s1 : none_q;

	// ring walk tests, second pass shifted by one second
	assign off      = pass_q ? (MS_W+1)'(MS_PER_S) : '0;
	assign tt       = {1'b0, t_ms} + off;
	assign win_end  = {1'b0, rd_entry.start} + {1'b0, rd_entry.duration};
	assign pass_end = (rd_entry.next == start_q) || (steps_q == IDX_W'(SLOTS-1));

	always_comb begin
		if (op_q == ACT_START) begin
			walk_hit = {1'b0, t_ms} <= ({1'b0, rd_entry.start} + off);
		end else begin
			walk_hit = (tt >= {1'b0, rd_entry.start}) && (tt < win_end);
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and read address
	always_comb begin
		state_d  = state_q;
		rd_addr  = qidx_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = in_query_index;
				if (in_acc) begin
					case (in_action)
						ACT_FIRST: state_d = ST_SCAN;
						ACT_NEXT:  state_d = ST_NX_CHECK;
						ACT_START: state_d = ST_SCAN;
						ACT_FIT:   state_d = ST_MOD_WAIT;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_MOD_WAIT: begin
				rd_addr = qidx_q;
				state_d = ST_WALK;
			end
			ST_SCAN: begin
				rd_addr = cnt_q[IDX_W-1:0];
				if (scan_hit || scan_miss) begin
					case (op_q)
						ACT_NEXT: begin
							rd_addr = scan_pos;
							state_d = ST_NX_FINAL;
						end
						ACT_START: begin
							rd_addr = scan_pos;
							state_d = ST_WALK;
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_NX_CHECK: begin
				if (rd_entry.zone == qzone_q) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_NX_FINAL: begin
				state_d = ST_RESP;
			end
			ST_WALK: begin
				if (walk_hit || (pass_end && pass_q)) begin
					state_d = ST_RESP;
				end else begin
					rd_addr = rd_entry.next;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// request and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q    <= in_action;
					qzone_q <= in_query_zone;
					qidx_q  <= in_query_index;
					tz_q    <= in_query_zone;
					ts_q    <= in_query_source;
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					res_q   <= '0;
					found_q <= 1'b0;
				end
			end
			ST_MOD_WAIT: begin
				cur_q   <= qidx_q;
				start_q <= qidx_q;
				steps_q <= '0;
				pass_q  <= 1'b0;
			end
			ST_SCAN: begin
				// issue one read a cycle, compare it in the cycle after
				pend_s1 <= (cnt_q != (IDX_W+1)'(SLOTS));
				pidx_s1 <= cnt_q[IDX_W-1:0];
				if (cnt_q != (IDX_W+1)'(SLOTS)) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (scan_hit || scan_miss) begin
					res_q   <= scan_pos;
					found_q <= scan_hit;
					cur_q   <= scan_pos;
					start_q <= scan_pos;
					steps_q <= '0;
					pass_q  <= 1'b0;
				end
			end
			ST_NX_CHECK: begin
				// zone unchanged answers straight away, else re-resolve
				res_q   <= rd_entry.next;
				found_q <= 1'b1;
				ts_q    <= rd_entry.source;
				cnt_q   <= '0;
				pend_s1 <= 1'b0;
			end
			ST_NX_FINAL: begin
				res_q <= rd_entry.next;
			end
			ST_WALK: begin
				if (walk_hit) begin
					res_q   <= cur_q;
					found_q <= 1'b1;
				end else if (pass_end && pass_q) begin
					res_q   <= none_q;
					found_q <= 1'b0;
				end else begin
					cur_q   <= rd_entry.next;
					steps_q <= pass_end ? '0 : steps_q + 1'b1;
					pass_q  <= pass_q | pass_end;
				end
			end
			default: begin
			end
		endcase
	end

	// none_index register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			none_q <= '0;
		end else if (cfg_we) begin
			none_q <= cfg_wdata;
		end
	end

	// answer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q  <= res_q;
			out_found_q <= found_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_found_q, out_slot_q};

`ifndef SYNTHESIS
	// an answer only appears after the response state
	a_answer_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_RESP)
		else $error("answer raised outside the response state");

	// a table write is answered without any lookup
	a_write_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_action == ACT_WRITE) |=> state_q == ST_RESP)
		else $error("write transaction did not go to the response state");

	// the second walk pass never falls back to the first
	a_pass_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && pass_q) |=> (pass_q || state_q != ST_WALK))
		else $error("ring walk pass went backwards");
`endif

endmodule
